/* rtl/lccrm_pkg.sv */
// package: widths, register indexes, config and pipeline types
`default_nettype none
package lccrm_pkg;
  localparam int RampDepth = 256;
  localparam int RampAw = $clog2(RampDepth);
  localparam int LogFracBits = 16;
  localparam int PhaseBits = LogFracBits + 16;
  localparam int LogBits = LogFracBits + 6;
  localparam int CfgAw = 2;
  localparam int CfgDw = 24;

  localparam logic [CfgAw-1:0] RegScale = 2'd0;
  localparam logic [CfgAw-1:0] RegPhase = 2'd1;
  localparam logic [CfgAw-1:0] RegLength = 2'd2;
  localparam logic [CfgAw-1:0] RegEnable = 2'd3;

  typedef struct packed {
    logic [23:0] scale;
    logic [15:0] phase_offset;
    logic [8:0]  ramp_length;
    logic        ramp_enabled;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [31:0] escape_value;
    logic [7:0]  entry_index;
    logic [23:0] entry_rgb;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_t;
endpackage
`default_nettype wire

/* rtl/lccrm_stream_if.sv */
// valid/ready stream interface carrying a payload type
`default_nettype none
interface lccrm_stream_if #(parameter type payload_t = logic) (input wire logic clk_i);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/lccrm_log2_unit.sv */
// pipelined fixed-point log2: normalize, then one squaring step per stage
`default_nettype none
module lccrm_log2_unit (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  en_i,
  input  wire logic                                  valid_i,
  input  wire logic [31:0]                           value_i,
  output logic                                       valid_o,
  output logic [lccrm_pkg::LogBits-1:0]              log_o
);
  localparam int N = lccrm_pkg::LogFracBits;

  logic [N:0]        vld_q;
  logic [31:0]       m_q   [N+1];
  logic [4:0]        p_q   [N+1];
  logic [N-1:0]      fr_q  [N+1];
  logic [4:0]        p_d;
  logic [31:0]       m_d;

  always_comb begin
    p_d = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (value_i[i]) p_d = 5'(i);
    end
    m_d = value_i << (5'd31 - p_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]  <= m_d;
      p_q[0]  <= p_d;
      fr_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = 64'(m_q[s]) * 64'(m_q[s]);
    assign t  = sq[63:31];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[s+1]  <= p_q[s];
        fr_q[s+1] <= {fr_q[s][N-2:0], t[32]};
        m_q[s+1]  <= t[32] ? t[32:1] : t[31:0];
      end
    end
  end

  assign valid_o = vld_q[N];
  assign log_o = {{(lccrm_pkg::LogBits-5-N){1'b0}}, p_q[N], fr_q[N]}
               - (lccrm_pkg::LogBits'(16) << N);
endmodule
`default_nettype wire

/* rtl/log_cyclic_color_ramp_mapper_core.sv */
// top level: escape-value colorer with logarithmic ramp cycling
//
// in_if carries items (action, escape_value, entry_index, entry_rgb); out_if
// carries one (red, green, blue, alpha) result per pixel item. A ramp-write
// item updates the ramp memory when it leaves the pipeline and gives no result.
// The block accepts one item per cycle while the skid buffer is not full. A pixel
// result passes the normalize stage and 16 squaring stages of the log2 unit, one
// scale multiply stage, one index and ramp memory read stage and the output
// register.
// Ramp writes and reads meet in program order at the memory port stage, so a
// pixel after a ramp write sees that write.
// When the receiver stalls, the whole pipeline holds once the two-entry skid buffer
// in front of out_if is full; until then that buffer keeps ready high.
// Reset clears pipeline valid bits and sets the registers to their defaults
// (scale 1.0, offset 0, length 256, ramp off). Ramp memory is not cleared.
// cfg_we_i writes register cfg_idx_i with cfg_data_i; do so only while idle.
`default_nettype none
module log_cyclic_color_ramp_mapper_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lccrm_pkg::CfgAw-1:0]    cfg_idx_i,
  input  wire logic [lccrm_pkg::CfgDw-1:0]    cfg_data_i,
  lccrm_stream_if.sink                        in_if,
  lccrm_stream_if.source                      out_if
);
  localparam int N = lccrm_pkg::LogFracBits;
  localparam int W = lccrm_pkg::PhaseBits;
  localparam int Aw = lccrm_pkg::RampAw;

  lccrm_pkg::cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale        <= 24'd65536;
      cfg_q.phase_offset <= '0;
      cfg_q.ramp_length  <= 9'd256;
      cfg_q.ramp_enabled <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lccrm_pkg::RegScale:  cfg_q.scale        <= cfg_data_i;
        lccrm_pkg::RegPhase:  cfg_q.phase_offset <= cfg_data_i[15:0];
        lccrm_pkg::RegLength: cfg_q.ramp_length  <= cfg_data_i[8:0];
        lccrm_pkg::RegEnable: cfg_q.ramp_enabled <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline advance; skid buffer of two entries absorbs the ready delay
  logic       en;
  logic [1:0] cnt_q;
  logic       pop;
  lccrm_pkg::out_t skid_q [2];
  logic       rd_q;

  assign en = (cnt_q != 2'd2);
  assign in_if.ready = en;
  wire in_xfer = in_if.valid && en;

  // side-band info shifted alongside the log2 unit
  localparam int L = N + 1;
  logic [L-1:0] act_q, zero_q;
  logic [Aw-1:0] eidx_q [L];
  logic [23:0]  rgb_q  [L];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
    end else if (en) begin
      act_q <= {act_q[L-2:0], in_xfer && in_if.data.action};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q   <= {zero_q[L-2:0], in_if.data.escape_value == 32'd0};
      eidx_q[0] <= in_if.data.entry_index[Aw-1:0];
      rgb_q[0]  <= in_if.data.entry_rgb;
      for (int i = 1; i < L; i++) begin
        eidx_q[i] <= eidx_q[i-1];
        rgb_q[i]  <= rgb_q[i-1];
      end
    end
  end

  logic lg_vld;
  logic [lccrm_pkg::LogBits-1:0] lg;
  lccrm_log2_unit u_log (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_xfer && !in_if.data.action),
    .value_i(in_if.data.escape_value),
    .valid_o(lg_vld), .log_o(lg)
  );

  // stage a: phase = log2 * scale + offset, low W bits
  logic           a_pix_q, a_wr_q, a_blk_q;
  logic [W-1:0]   a_f_q;
  logic [Aw-1:0]  a_eidx_q;
  logic [23:0]    a_rgb_q;
  logic [W-1:0]   prod;
  assign prod = {{(W-lccrm_pkg::LogBits){lg[lccrm_pkg::LogBits-1]}}, lg}
              * W'(cfg_q.scale);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_pix_q <= 1'b0;
      a_wr_q  <= 1'b0;
    end else if (en) begin
      a_pix_q <= lg_vld;
      a_wr_q  <= act_q[L-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_f_q    <= prod + (W'(cfg_q.phase_offset) << N);
      a_blk_q  <= zero_q[L-1] || !cfg_q.ramp_enabled;
      a_eidx_q <= eidx_q[L-1];
      a_rgb_q  <= rgb_q[L-1];
    end
  end

  // stage b: index = floor(len * (2^W - f) / 2^W), clamped
  logic [8:0]    len;
  logic [W:0]    comp;
  logic [W+9:0]  mul;
  logic [9:0]    idx_raw;
  logic [Aw-1:0] idx;
  always_comb begin
    len = (cfg_q.ramp_length > 9'(lccrm_pkg::RampDepth)) ? 9'(lccrm_pkg::RampDepth)
                                                          : cfg_q.ramp_length;
    comp = {1'b1, {W{1'b0}}} - {1'b0, a_f_q};
    mul = (W+10)'(len) * (W+10)'(comp);
    idx_raw = mul[W+9:W];
    if (len == 9'd0) idx = '0;
    else if (idx_raw > 10'(len - 9'd1)) idx = Aw'(len - 9'd1);
    else idx = idx_raw[Aw-1:0];
  end

  logic           b_pix_q, b_blk_q;
  logic [23:0]    ram [lccrm_pkg::RampDepth];
  logic [23:0]    ram_rd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_pix_q <= 1'b0;
    else if (en) b_pix_q <= a_pix_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_blk_q <= a_blk_q;
      if (a_wr_q) ram[a_eidx_q] <= a_rgb_q;
      ram_rd_q <= ram[idx];
    end
  end

  lccrm_pkg::out_t res;
  always_comb begin
    if (b_blk_q) res = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd1};
    else res = '{red: ram_rd_q[23:16], green: ram_rd_q[15:8], blue: ram_rd_q[7:0],
                 alpha: 8'd255};
  end

  // skid fifo
  logic push;
  assign push = en && b_pix_q;
  assign pop = out_if.valid && out_if.ready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
      if (pop) rd_q <= ~rd_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) skid_q[rd_q ^ cnt_q[0]] <= res;
  end
  assign out_if.valid = cnt_q != 2'd0;
  assign out_if.data = skid_q[rd_q];
endmodule
`default_nettype wire

/* rtl/lccrm_checker.sv */
// port-level checker bound to the top level
`default_nettype none
module lccrm_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] out_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_data[7:0] == 8'd1 || out_data[7:0] == 8'd255)) else $error("alpha");
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data[7:0] == 8'd1 |-> out_data[31:8] == 24'd0) else $error("black");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("ready");
endmodule
bind log_cyclic_color_ramp_mapper_core lccrm_checker u_chk (
  .clk_i, .rst_ni, .in_ready(in_if.ready), .out_valid(out_if.valid),
  .out_ready(out_if.ready), .out_data(out_if.data)
);
`default_nettype wire

/* tb/tb_log_cyclic_color_ramp_mapper_core.sv */
// testbench for the log-cyclic color ramp mapper: random streams checked against a predictor
`timescale 1ns / 100ps

module tb_log_cyclic_color_ramp_mapper_core;

  // holds ramp contents and register copies, predicts colors per pixel transfer
  class color_scoreboard;
    logic [23:0] ramp_mem [lccrm_pkg::RampDepth];
    lccrm_pkg::cfg_t regs;
    lccrm_pkg::out_t pending_colors [$];
    int          mismatches;

    function void reset_regs();
      regs.scale        = 24'd65536;
      regs.phase_offset = 16'd0;
      regs.ramp_length  = 9'd256;
      regs.ramp_enabled = 1'b0;
      mismatches        = 0;
    endfunction

    function void set_reg(logic [lccrm_pkg::CfgAw-1:0] idx,
                          logic [lccrm_pkg::CfgDw-1:0] val);
      case (idx)
        lccrm_pkg::RegScale:  regs.scale = val[23:0];
        lccrm_pkg::RegPhase:  regs.phase_offset = val[15:0];
        lccrm_pkg::RegLength: regs.ramp_length = val[8:0];
        lccrm_pkg::RegEnable: regs.ramp_enabled = val[0];
        default: ;
      endcase
    endfunction

    // log2 of an unsigned Q16.16 value, returned in two's complement, LogFracBits fraction bits
    function bit [63:0] log2_q(bit [31:0] v);
      int          lead;
      bit [63:0]   mant;
      bit [63:0]   frac;
      lead = 31;
      frac = 0;
      while (lead > 0 && !v[lead]) lead--;
      mant = ({32'b0, v} << (31 - lead)) & 64'hFFFF_FFFF;
      for (int i = 0; i < lccrm_pkg::LogFracBits; i++) begin
        mant = (mant * mant) >> 31;
        frac = frac << 1;
        if (mant >= 64'h1_0000_0000) begin
          frac = frac | 64'd1;
          mant = mant >> 1;
        end
      end
      return (64'(lead) << lccrm_pkg::LogFracBits)
           - (64'd16 << lccrm_pkg::LogFracBits) + frac;
    endfunction

    function void note_input(lccrm_pkg::in_t it);
      bit [63:0] total;
      bit [63:0] f;
      bit [63:0] len;
      bit [63:0] idx;
      logic [23:0] rgb;
      lccrm_pkg::out_t exp_c;
      if (it.action) begin
        ramp_mem[it.entry_index] = it.entry_rgb;
        return;
      end
      if (it.escape_value == 0 || !regs.ramp_enabled) begin
        exp_c = '{8'd0, 8'd0, 8'd0, 8'd1};
      end else begin
        total = log2_q(it.escape_value) * 64'(regs.scale)
              + (64'(regs.phase_offset) << lccrm_pkg::LogFracBits);
        f = total & 64'hFFFF_FFFF;
        len = 64'(regs.ramp_length);
        if (len > lccrm_pkg::RampDepth) len = lccrm_pkg::RampDepth;
        if (len == 0) begin
          idx = 0;
        end else begin
          idx = (len * (64'h1_0000_0000 - f)) >> lccrm_pkg::PhaseBits;
          if (idx > len - 1) idx = len - 1;
        end
        rgb = ramp_mem[idx[lccrm_pkg::RampAw-1:0]];
        exp_c = '{rgb[23:16], rgb[15:8], rgb[7:0], 8'd255};
      end
      pending_colors.push_back(exp_c);
    endfunction

    function void check(lccrm_pkg::out_t got);
      lccrm_pkg::out_t exp_c;
      if (pending_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected color transfer %h", got);
        return;
      end
      exp_c = pending_colors.pop_front();
      if (got.red !== exp_c.red || got.green !== exp_c.green ||
          got.blue !== exp_c.blue || got.alpha !== exp_c.alpha) begin
        mismatches++;
        if (mismatches <= 10)
          $display("color mismatch: expected r%h g%h b%h a%h, got r%h g%h b%h a%h",
                   exp_c.red, exp_c.green, exp_c.blue, exp_c.alpha,
                   got.red, got.green, got.blue, got.alpha);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [lccrm_pkg::CfgAw-1:0] cfg_idx_i = '0;
  logic [lccrm_pkg::CfgDw-1:0] cfg_data_i = '0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  color_scoreboard sb;

  lccrm_stream_if #(.payload_t(lccrm_pkg::in_t))  in_if  (clk_i);
  lccrm_stream_if #(.payload_t(lccrm_pkg::out_t)) out_if (clk_i);

  log_cyclic_color_ramp_mapper_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_if), .out_if(out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) sb.note_input(in_if.data);
    if (rst_ni && out_if.valid && out_if.ready) sb.check(out_if.data);
  end

  task automatic push_item(lccrm_pkg::in_t it);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic pixel(logic [31:0] v);
    push_item('{1'b0, v, 8'($urandom), 24'($urandom)});
  endtask

  task automatic ramp_write(logic [7:0] idx, logic [23:0] rgb);
    push_item('{1'b1, $urandom, idx, rgb});
  endtask

  // drains the pipeline; ramp writes leave no result, so wait out the latency too
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_colors.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [lccrm_pkg::CfgAw-1:0] idx,
                           logic [lccrm_pkg::CfgDw-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_setting();
    case ($urandom_range(0, 3))
      0: write_reg(lccrm_pkg::RegScale, 24'd0);
      1: write_reg(lccrm_pkg::RegScale, 24'hFFFFFF);
      2: write_reg(lccrm_pkg::RegScale, 24'd65536);
      default: write_reg(lccrm_pkg::RegScale, 24'($urandom));
    endcase
    case ($urandom_range(0, 2))
      0: write_reg(lccrm_pkg::RegPhase, 24'd0);
      1: write_reg(lccrm_pkg::RegPhase, 24'hFFFF);
      default: write_reg(lccrm_pkg::RegPhase, 24'($urandom_range(0, 65535)));
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(lccrm_pkg::RegLength, 24'd1);
      1: write_reg(lccrm_pkg::RegLength, 24'd256);
      2: write_reg(lccrm_pkg::RegLength, 24'd0);
      3: write_reg(lccrm_pkg::RegLength, 24'($urandom_range(257, 511)));
      default: write_reg(lccrm_pkg::RegLength, 24'($urandom_range(2, 255)));
    endcase
    write_reg(lccrm_pkg::RegEnable, 24'($urandom_range(0, 5) != 0));
  endtask

  task automatic random_items(int count);
    logic [31:0] v;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        ramp_write(8'($urandom), 24'($urandom));
      end else begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 30) == 0) v = 32'd0;
        pixel(v);
      end
    end
  endtask

  initial begin
    sb = new();
    sb.reset_regs();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load every ramp entry so no pixel reads an unwritten one
    for (int i = 0; i < lccrm_pkg::RampDepth; i++) ramp_write(8'(i), 24'($urandom));
    pixel(32'h0001_0000);
    drain();
    write_reg(lccrm_pkg::RegEnable, 24'd1);
    pixel(32'd0);
    pixel(32'd1);
    pixel(32'hFFFF_FFFF);
    pixel(32'h0001_0000); // fraction zero, clamps to the last entry
    pixel(32'h8000_0000);
    ramp_write(8'd255, 24'hFFFFFF);
    pixel(32'h0001_0000);
    ramp_write(8'd0, 24'h000000);
    ramp_write(8'd255, 24'hA5C3F0);
    pixel(32'h0001_0000);
    drain();
    write_reg(lccrm_pkg::RegScale, 24'hFFFFFF);
    write_reg(lccrm_pkg::RegPhase, 24'hFFFF);
    write_reg(lccrm_pkg::RegLength, 24'd0);
    pixel(32'h0003_0000);
    pixel(32'h0000_8000);
    drain();
    write_reg(lccrm_pkg::RegLength, 24'd511);
    write_reg(lccrm_pkg::RegScale, 24'd0);
    pixel(32'h1234_5678);
    pixel(32'h0000_0001);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      random_setting();
      random_items(60);
      drain(); // sender holds off until every color is back
      random_items(55);
      drain();
    end

    if (sb.pending_colors.size() != 0) sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
